[rtl/rbv_pkg.sv]
// ----------------------------------------------------------------------------
// rbv_pkg
// Shared widths, defaults and the rounding helper of the vector-to-vector
// rotation core.
// ----------------------------------------------------------------------------
package rbv_pkg;

    localparam int DEF_COMPONENT_WIDTH = 16;
    localparam int DEF_OUT_FRAC_BITS   = 14;

    // Internal fixed point is Q1.30.
    localparam int IFRAC  = 30;
    // Unit vector component: magnitude up to 1.0, signed.
    localparam int UNIT_W = IFRAC + 2;
    // Cross product term after rounding back to Q1.30.
    localparam int S_W    = IFRAC + 3;
    // Cosine and one minus cosine.
    localparam int C_W    = IFRAC + 4;
    // Scaled axis components (1-c)v.
    localparam int VT_W   = IFRAC + 4;
    // Working width for rounding shifts.
    localparam int WIDE_W = 72;

    typedef struct packed {
        logic en;
        logic valid;
    } stage_ctl_t;

    // Arithmetic right shift by n, rounding to nearest with ties away from zero.
    function automatic logic signed [WIDE_W-1:0] rshr(input logic signed [WIDE_W-1:0] x,
                                                      input int unsigned n);
        logic signed [WIDE_W-1:0] half;
        logic signed [WIDE_W-1:0] adj;
        logic signed [WIDE_W-1:0] total;
        half = '0;
        if (n == 0)
        begin
            return x;
        end
        half[n-1] = 1'b1;
        adj = x[WIDE_W-1] ? (half - 72'sd1) : half;
        total = x + adj;
        return total >>> n;
    endfunction

endpackage

[rtl/rbv_if.sv]
// ----------------------------------------------------------------------------
// rbv_if
// Valid/ready channels of the rotation core: vector pair requests in,
// rotation matrix requests out.
// ----------------------------------------------------------------------------
interface rbv_vec_if #(parameter int W = rbv_pkg::DEF_COMPONENT_WIDTH);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] from_x;
    logic signed [W-1:0] from_y;
    logic signed [W-1:0] from_z;
    logic signed [W-1:0] to_x;
    logic signed [W-1:0] to_y;
    logic signed [W-1:0] to_z;

    modport source (output valid, from_x, from_y, from_z, to_x, to_y, to_z, input ready);
    modport sink   (input valid, from_x, from_y, from_z, to_x, to_y, to_z, output ready);
endinterface

interface rbv_mat_if #(parameter int W = rbv_pkg::DEF_OUT_FRAC_BITS + 2);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] m00;
    logic signed [W-1:0] m01;
    logic signed [W-1:0] m02;
    logic signed [W-1:0] m10;
    logic signed [W-1:0] m11;
    logic signed [W-1:0] m12;
    logic signed [W-1:0] m20;
    logic signed [W-1:0] m21;
    logic signed [W-1:0] m22;
    logic                degenerate;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, degenerate,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, degenerate,
                    output ready);
endinterface

[rtl/rotation_between_vectors_core.sv]
// ----------------------------------------------------------------------------
// rotation_between_vectors_core
// Rotation matrix that turns one 3-vector onto another (Rodrigues form),
// signed Q1.OUT_FRAC_BITS output with saturation.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the skid entry is empty; each of
// the three normalizers is a 70-stage pipeline with one square-root bit and
// one quotient bit per stage. A two-entry output register with skid keeps
// the input side running until a result meets a stalled output and is
// parked in the skid entry; then the whole pipeline holds.
// Reset clears all valid bits; data registers are not reset.
module rotation_between_vectors_core #(
    parameter int COMPONENT_WIDTH = rbv_pkg::DEF_COMPONENT_WIDTH,
    parameter int OUT_FRAC_BITS   = rbv_pkg::DEF_OUT_FRAC_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    rbv_vec_if.sink    vec,
    rbv_mat_if.source  mat
);

    localparam int CW     = COMPONENT_WIDTH;
    localparam int PW     = 2 * CW;
    localparam int OUT_W  = OUT_FRAC_BITS + 2;
    localparam int UW     = rbv_pkg::UNIT_W;
    localparam int XW     = 2 * UW + 2;
    localparam int PR_W   = rbv_pkg::C_W + UW;
    localparam int SUM_W  = rbv_pkg::VT_W + 2;
    localparam int SIDE_W = 3 * rbv_pkg::S_W + rbv_pkg::C_W + 1;
    localparam int WW     = rbv_pkg::WIDE_W;

    localparam logic signed [rbv_pkg::C_W-1:0] ONE_C = rbv_pkg::C_W'(64'sd1 <<< rbv_pkg::IFRAC);
    localparam logic signed [WW-1:0] LIM_POS = WW'(72'sd1 <<< OUT_FRAC_BITS);
    localparam logic signed [WW-1:0] LIM_NEG = -LIM_POS;

    logic en;
    logic skid_valid_reg;
    logic out_valid_reg;

    assign en        = !skid_valid_reg;
    assign vec.ready = en;

    // P1: register the request and the six cross terms of the raw inputs.
    logic                   p1_valid_reg;
    logic signed [CW-1:0]   p1_a_reg [3];
    logic signed [CW-1:0]   p1_b_reg [3];
    logic signed [PW-1:0]   p1_pr_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= vec.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_a_reg[0]  <= vec.from_x;
            p1_a_reg[1]  <= vec.from_y;
            p1_a_reg[2]  <= vec.from_z;
            p1_b_reg[0]  <= vec.to_x;
            p1_b_reg[1]  <= vec.to_y;
            p1_b_reg[2]  <= vec.to_z;
            p1_pr_reg[0] <= PW'(vec.from_y) * PW'(vec.to_z);
            p1_pr_reg[1] <= PW'(vec.from_z) * PW'(vec.to_y);
            p1_pr_reg[2] <= PW'(vec.from_z) * PW'(vec.to_x);
            p1_pr_reg[3] <= PW'(vec.from_x) * PW'(vec.to_z);
            p1_pr_reg[4] <= PW'(vec.from_x) * PW'(vec.to_y);
            p1_pr_reg[5] <= PW'(vec.from_y) * PW'(vec.to_x);
        end
    end

    // P2: the exact cross product vanishes when all three pairs agree.
    logic                   p2_valid_reg;
    logic signed [CW-1:0]   p2_a_reg [3];
    logic signed [CW-1:0]   p2_b_reg [3];
    logic [2:0]             p2_eq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_a_reg     <= p1_a_reg;
            p2_b_reg     <= p1_b_reg;
            p2_eq_reg[0] <= (p1_pr_reg[0] == p1_pr_reg[1]);
            p2_eq_reg[1] <= (p1_pr_reg[2] == p1_pr_reg[3]);
            p2_eq_reg[2] <= (p1_pr_reg[4] == p1_pr_reg[5]);
        end
    end

    // Normalize both vectors side by side; the equality flags ride along.
    rbv_pkg::stage_ctl_t   ab_ctl;
    logic                  ua_valid;
    logic                  ub_valid;
    logic signed [UW-1:0]  ua_u [3];
    logic signed [UW-1:0]  ub_u [3];
    logic [0:0]            ua_side;
    logic [1:0]            ub_side;

    assign ab_ctl.en    = en;
    assign ab_ctl.valid = p2_valid_reg;

    rbv_unitize #(
        .IN_W   (CW),
        .SIDE_W (1)
    ) u_norm_from (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ab_ctl),
        .a        (p2_a_reg),
        .side_in  (p2_eq_reg[0]),
        .valid    (ua_valid),
        .u        (ua_u),
        .side_out (ua_side)
    );

    rbv_unitize #(
        .IN_W   (CW),
        .SIDE_W (2)
    ) u_norm_to (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ab_ctl),
        .a        (p2_b_reg),
        .side_in  (p2_eq_reg[2:1]),
        .valid    (ub_valid),
        .u        (ub_u),
        .side_out (ub_side)
    );

    // C1: all nine products of the unit components.
    logic                      c1_valid_reg;
    logic                      c1_degen_reg;
    logic signed [2*UW-1:0]    c1_uw_reg [3][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c1_valid_reg <= ua_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_degen_reg <= ua_side[0] & ub_side[0] & ub_side[1];
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    c1_uw_reg[i][j] <= (2*UW)'(ua_u[i]) * (2*UW)'(ub_u[j]);
                end
            end
        end
    end

    // C2: cross product and dot product at full width.
    logic                  c2_valid_reg;
    logic                  c2_degen_reg;
    logic signed [XW-1:0]  c2_x_reg [3];
    logic signed [XW-1:0]  c2_dot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c2_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2_degen_reg <= c1_degen_reg;
            c2_x_reg[0]  <= XW'(c1_uw_reg[1][2]) - XW'(c1_uw_reg[2][1]);
            c2_x_reg[1]  <= XW'(c1_uw_reg[2][0]) - XW'(c1_uw_reg[0][2]);
            c2_x_reg[2]  <= XW'(c1_uw_reg[0][1]) - XW'(c1_uw_reg[1][0]);
            c2_dot_reg   <= XW'(c1_uw_reg[0][0]) + XW'(c1_uw_reg[1][1])
                            + XW'(c1_uw_reg[2][2]);
        end
    end

    // C3: back to Q1.30; a degenerate pair has its axis forced to zero.
    logic                               c3_valid_reg;
    logic                               c3_degen_reg;
    logic signed [rbv_pkg::S_W-1:0]     c3_s_reg [3];
    logic signed [rbv_pkg::C_W-1:0]     c3_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c3_valid_reg <= c2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c3_degen_reg <= c2_degen_reg;
            c3_c_reg <= rbv_pkg::C_W'(rbv_pkg::rshr(WW'(c2_dot_reg), rbv_pkg::IFRAC));
            for (int i = 0; i < 3; i++)
            begin
                if (c2_degen_reg)
                begin
                    c3_s_reg[i] <= '0;
                end
                else
                begin
                    c3_s_reg[i] <= rbv_pkg::S_W'(rbv_pkg::rshr(WW'(c2_x_reg[i]),
                                                                rbv_pkg::IFRAC));
                end
            end
        end
    end

    // Normalize the axis; s, c and the degenerate flag ride along.
    rbv_pkg::stage_ctl_t   s_ctl;
    logic [SIDE_W-1:0]     s_side_in;
    logic [SIDE_W-1:0]     s_side_out;
    logic                  us_valid;
    logic signed [UW-1:0]  us_v [3];

    assign s_ctl.en    = en;
    assign s_ctl.valid = c3_valid_reg;
    assign s_side_in   = {c3_s_reg[0], c3_s_reg[1], c3_s_reg[2], c3_c_reg, c3_degen_reg};

    rbv_unitize #(
        .IN_W   (rbv_pkg::S_W),
        .SIDE_W (SIDE_W)
    ) u_norm_axis (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (s_ctl),
        .a        (c3_s_reg),
        .side_in  (s_side_in),
        .valid    (us_valid),
        .u        (us_v),
        .side_out (s_side_out)
    );

    logic signed [rbv_pkg::S_W-1:0]  ax_s [3];
    logic signed [rbv_pkg::C_W-1:0]  ax_c;
    logic                            ax_degen;

    assign {ax_s[0], ax_s[1], ax_s[2], ax_c, ax_degen} = s_side_out;

    // D1: one minus cosine.
    logic                               d1_valid_reg;
    logic                               d1_degen_reg;
    logic signed [rbv_pkg::C_W-1:0]     d1_omc_reg;
    logic signed [rbv_pkg::C_W-1:0]     d1_c_reg;
    logic signed [rbv_pkg::S_W-1:0]     d1_s_reg [3];
    logic signed [UW-1:0]               d1_v_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d1_valid_reg <= us_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_degen_reg <= ax_degen;
            d1_omc_reg   <= ONE_C - ax_c;
            d1_c_reg     <= ax_c;
            d1_s_reg     <= ax_s;
            d1_v_reg     <= us_v;
        end
    end

    // D2: (1-c) v_i at full width.
    logic                               d2_valid_reg;
    logic                               d2_degen_reg;
    logic signed [rbv_pkg::C_W-1:0]     d2_c_reg;
    logic signed [rbv_pkg::S_W-1:0]     d2_s_reg [3];
    logic signed [UW-1:0]               d2_v_reg [3];
    logic signed [PR_W-1:0]             d2_pr_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d2_valid_reg <= d1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_degen_reg <= d1_degen_reg;
            d2_c_reg     <= d1_c_reg;
            d2_s_reg     <= d1_s_reg;
            d2_v_reg     <= d1_v_reg;
            for (int i = 0; i < 3; i++)
            begin
                d2_pr_reg[i] <= PR_W'(d1_omc_reg) * PR_W'(d1_v_reg[i]);
            end
        end
    end

    // D3: round the scaled axis back to Q1.30.
    logic                               d3_valid_reg;
    logic                               d3_degen_reg;
    logic signed [rbv_pkg::C_W-1:0]     d3_c_reg;
    logic signed [rbv_pkg::S_W-1:0]     d3_s_reg [3];
    logic signed [UW-1:0]               d3_v_reg [3];
    logic signed [rbv_pkg::VT_W-1:0]    d3_vt_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d3_valid_reg <= d2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d3_degen_reg <= d2_degen_reg;
            d3_c_reg     <= d2_c_reg;
            d3_s_reg     <= d2_s_reg;
            d3_v_reg     <= d2_v_reg;
            for (int i = 0; i < 3; i++)
            begin
                d3_vt_reg[i] <= rbv_pkg::VT_W'(rbv_pkg::rshr(WW'(d2_pr_reg[i]),
                                                              rbv_pkg::IFRAC));
            end
        end
    end

    // D4: the six distinct quadratic terms: 00, 11, 22, 01, 20, 12.
    logic                               d4_valid_reg;
    logic                               d4_degen_reg;
    logic signed [rbv_pkg::C_W-1:0]     d4_c_reg;
    logic signed [rbv_pkg::S_W-1:0]     d4_s_reg [3];
    logic signed [PR_W-1:0]             d4_pr_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d4_valid_reg <= d3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d4_degen_reg <= d3_degen_reg;
            d4_c_reg     <= d3_c_reg;
            d4_s_reg     <= d3_s_reg;
            d4_pr_reg[0] <= PR_W'(d3_vt_reg[0]) * PR_W'(d3_v_reg[0]);
            d4_pr_reg[1] <= PR_W'(d3_vt_reg[1]) * PR_W'(d3_v_reg[1]);
            d4_pr_reg[2] <= PR_W'(d3_vt_reg[2]) * PR_W'(d3_v_reg[2]);
            d4_pr_reg[3] <= PR_W'(d3_vt_reg[0]) * PR_W'(d3_v_reg[1]);
            d4_pr_reg[4] <= PR_W'(d3_vt_reg[2]) * PR_W'(d3_v_reg[0]);
            d4_pr_reg[5] <= PR_W'(d3_vt_reg[1]) * PR_W'(d3_v_reg[2]);
        end
    end

    // D5: round the quadratic terms.
    logic                               d5_valid_reg;
    logic                               d5_degen_reg;
    logic signed [rbv_pkg::C_W-1:0]     d5_c_reg;
    logic signed [rbv_pkg::S_W-1:0]     d5_s_reg [3];
    logic signed [rbv_pkg::VT_W-1:0]    d5_t_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d5_valid_reg <= d4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d5_degen_reg <= d4_degen_reg;
            d5_c_reg     <= d4_c_reg;
            d5_s_reg     <= d4_s_reg;
            for (int k = 0; k < 6; k++)
            begin
                d5_t_reg[k] <= rbv_pkg::VT_W'(rbv_pkg::rshr(WW'(d4_pr_reg[k]),
                                                             rbv_pkg::IFRAC));
            end
        end
    end

    // D6: matrix entries in Q1.30, row-major.
    logic                         d6_valid_reg;
    logic                         d6_degen_reg;
    logic signed [SUM_W-1:0]      d6_sum_reg [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d6_valid_reg <= d5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d6_degen_reg  <= d5_degen_reg;
            d6_sum_reg[0] <= SUM_W'(d5_t_reg[0]) + SUM_W'(d5_c_reg);
            d6_sum_reg[1] <= SUM_W'(d5_t_reg[3]) - SUM_W'(d5_s_reg[2]);
            d6_sum_reg[2] <= SUM_W'(d5_t_reg[4]) + SUM_W'(d5_s_reg[1]);
            d6_sum_reg[3] <= SUM_W'(d5_t_reg[3]) + SUM_W'(d5_s_reg[2]);
            d6_sum_reg[4] <= SUM_W'(d5_t_reg[1]) + SUM_W'(d5_c_reg);
            d6_sum_reg[5] <= SUM_W'(d5_t_reg[5]) - SUM_W'(d5_s_reg[0]);
            d6_sum_reg[6] <= SUM_W'(d5_t_reg[4]) - SUM_W'(d5_s_reg[1]);
            d6_sum_reg[7] <= SUM_W'(d5_t_reg[5]) + SUM_W'(d5_s_reg[0]);
            d6_sum_reg[8] <= SUM_W'(d5_t_reg[2]) + SUM_W'(d5_c_reg);
        end
    end

    // D7: round to the output format and saturate to +-1.0.
    logic                         d7_valid_reg;
    logic                         d7_degen_reg;
    logic signed [OUT_W-1:0]      d7_m_reg [9];
    logic signed [WW-1:0]         q_wide [9];
    logic signed [OUT_W-1:0]      d7_m_next [9];

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            q_wide[k] = rbv_pkg::rshr(WW'(d6_sum_reg[k]), rbv_pkg::IFRAC - OUT_FRAC_BITS);
            if (q_wide[k] > LIM_POS)
            begin
                d7_m_next[k] = OUT_W'(LIM_POS);
            end
            else if (q_wide[k] < LIM_NEG)
            begin
                d7_m_next[k] = OUT_W'(LIM_NEG);
            end
            else
            begin
                d7_m_next[k] = OUT_W'(q_wide[k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d7_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d7_valid_reg <= d6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d7_degen_reg <= d6_degen_reg;
            d7_m_reg     <= d7_m_next;
        end
    end

    // Output register with one skid entry. The pipeline advances only while
    // the skid entry is empty, so a result that meets a stalled output is
    // parked there and the next cycle holds everything upstream.
    logic                     push;
    logic                     pop;
    logic signed [OUT_W-1:0]  out_m_reg  [9];
    logic                     out_degen_reg;
    logic signed [OUT_W-1:0]  skid_m_reg [9];
    logic                     skid_degen_reg;

    assign push = en && d7_valid_reg;
    assign pop  = out_valid_reg && mat.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_m_reg     <= skid_m_reg;
                out_degen_reg <= skid_degen_reg;
            end
            else
            begin
                out_m_reg     <= d7_m_reg;
                out_degen_reg <= d7_degen_reg;
            end
        end
        else if (push)
        begin
            skid_m_reg     <= d7_m_reg;
            skid_degen_reg <= d7_degen_reg;
        end
    end

    assign mat.valid      = out_valid_reg;
    assign mat.m00        = out_m_reg[0];
    assign mat.m01        = out_m_reg[1];
    assign mat.m02        = out_m_reg[2];
    assign mat.m10        = out_m_reg[3];
    assign mat.m11        = out_m_reg[4];
    assign mat.m12        = out_m_reg[5];
    assign mat.m20        = out_m_reg[6];
    assign mat.m21        = out_m_reg[7];
    assign mat.m22        = out_m_reg[8];
    assign mat.degenerate = out_degen_reg;

    // The two input normalizers run in lockstep.
    a_norm_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        ua_valid == ub_valid)
        else $error("vector normalizers out of step");

    // The skid entry is only ever filled behind a held output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // A degenerate pair has no axis, so the matrix is c times the identity.
    a_degen_scaled_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_degen_reg) |->
            (out_m_reg[1] == '0 && out_m_reg[2] == '0 && out_m_reg[3] == '0 &&
             out_m_reg[5] == '0 && out_m_reg[6] == '0 && out_m_reg[7] == '0 &&
             out_m_reg[0] == out_m_reg[4] && out_m_reg[4] == out_m_reg[8]))
        else $error("degenerate result is not a scaled identity");

endmodule

[rtl/rbv_unitize.sv]
// ----------------------------------------------------------------------------
// rbv_unitize
// Pipelined 3-vector normalizer: aligns the magnitudes, takes the integer
// square root of the sum of squares one bit per stage and divides by it one
// quotient bit per stage. The result is a unit vector in Q1.30.
// ----------------------------------------------------------------------------
module rbv_unitize #(
    parameter int IN_W   = rbv_pkg::DEF_COMPONENT_WIDTH,
    parameter int SIDE_W = 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rbv_pkg::stage_ctl_t                ctl,
    input  logic signed [IN_W-1:0]             a [3],
    input  logic [SIDE_W-1:0]                  side_in,
    output logic                               valid,
    output logic signed [rbv_pkg::UNIT_W-1:0]  u [3],
    output logic [SIDE_W-1:0]                  side_out
);

    localparam int POS_W      = $clog2(IN_W);
    localparam int NRM_W      = rbv_pkg::IFRAC;
    localparam int SQ_W       = 2 * NRM_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int RES_W      = SUM_W + 1;
    localparam int LEN_W      = NRM_W + 1;
    localparam int ROOT_STEPS = LEN_W;
    localparam int NUM_W      = 2 * NRM_W + 1;
    localparam int Q_W        = LEN_W;
    localparam int DIV_STEPS  = Q_W;

    typedef struct packed {
        logic [2:0]              neg;
        logic                    zero;
        logic [SIDE_W-1:0]       side;
        logic [2:0][NRM_W-1:0]   nm;
    } carry_t;

    // Stage 1: sign and magnitude.
    logic                s1_valid_reg;
    logic [2:0]          s1_neg_reg;
    logic [IN_W-1:0]     s1_mag_reg [3];
    logic [SIDE_W-1:0]   s1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            s1_valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_neg_reg[i] <= a[i][IN_W-1];
                s1_mag_reg[i] <= a[i][IN_W-1] ? IN_W'(-a[i]) : IN_W'(a[i]);
            end
            s1_side_reg <= side_in;
        end
    end

    // Stage 2: largest magnitude.
    logic                s2_valid_reg;
    logic [2:0]          s2_neg_reg;
    logic [IN_W-1:0]     s2_mag_reg [3];
    logic [IN_W-1:0]     s2_max_reg;
    logic [SIDE_W-1:0]   s2_side_reg;
    logic [IN_W-1:0]     s2_max_next;

    always_comb
    begin
        s2_max_next = s1_mag_reg[0];
        if (s1_mag_reg[1] > s2_max_next)
        begin
            s2_max_next = s1_mag_reg[1];
        end
        if (s1_mag_reg[2] > s2_max_next)
        begin
            s2_max_next = s1_mag_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            s2_neg_reg  <= s1_neg_reg;
            s2_mag_reg  <= s1_mag_reg;
            s2_max_reg  <= s2_max_next;
            s2_side_reg <= s1_side_reg;
        end
    end

    // Stage 3: position of the leading one of the largest magnitude.
    logic                s3_valid_reg;
    logic [2:0]          s3_neg_reg;
    logic [IN_W-1:0]     s3_mag_reg [3];
    logic [POS_W-1:0]    s3_pos_reg;
    logic                s3_zero_reg;
    logic [SIDE_W-1:0]   s3_side_reg;
    logic [POS_W-1:0]    s3_pos_next;

    always_comb
    begin
        s3_pos_next = '0;
        for (int b = 0; b < IN_W; b++)
        begin
            if (s2_max_reg[b])
            begin
                s3_pos_next = POS_W'(b);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            s3_neg_reg  <= s2_neg_reg;
            s3_mag_reg  <= s2_mag_reg;
            s3_pos_reg  <= s3_pos_next;
            s3_zero_reg <= (s2_max_reg == '0);
            s3_side_reg <= s2_side_reg;
        end
    end

    // Stage 4: align so that the largest magnitude lies in [2^29, 2^30).
    // Shifting left by 29 and then right by the leading-one position does
    // both directions at once; bits shifted out on the right are dropped.
    logic     s4_valid_reg;
    carry_t   s4_car_reg;
    carry_t   s4_car_next;

    always_comb
    begin
        s4_car_next.neg  = s3_neg_reg;
        s4_car_next.zero = s3_zero_reg;
        s4_car_next.side = s3_side_reg;
        for (int i = 0; i < 3; i++)
        begin
            s4_car_next.nm[i] = NRM_W'({s3_mag_reg[i], {(NRM_W-1){1'b0}}} >> s3_pos_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            s4_car_reg <= s4_car_next;
        end
    end

    // Stage 5: squares.
    logic              s5_valid_reg;
    carry_t            s5_car_reg;
    logic [SQ_W-1:0]   s5_sq_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            s5_car_reg <= s4_car_reg;
            for (int i = 0; i < 3; i++)
            begin
                s5_sq_reg[i] <= SQ_W'(s4_car_reg.nm[i]) * SQ_W'(s4_car_reg.nm[i]);
            end
        end
    end

    // Square root, one result bit per stage. Entry 0 is the sum of squares.
    logic               rt_valid_reg [ROOT_STEPS+1];
    carry_t             rt_car_reg   [ROOT_STEPS+1];
    logic [SUM_W-1:0]   rt_n_reg     [ROOT_STEPS+1];
    logic [RES_W-1:0]   rt_res_reg   [ROOT_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rt_valid_reg[0] <= 1'b0;
        end
        else if (ctl.en)
        begin
            rt_valid_reg[0] <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            rt_car_reg[0] <= s5_car_reg;
            rt_n_reg[0]   <= SUM_W'(s5_sq_reg[0]) + SUM_W'(s5_sq_reg[1]) + SUM_W'(s5_sq_reg[2]);
            rt_res_reg[0] <= '0;
        end
    end

    for (genvar t = 0; t < ROOT_STEPS; t++)
    begin : g_root
        localparam logic [RES_W-1:0] BIT = RES_W'(1) << (2 * (ROOT_STEPS - 1 - t));
        logic [RES_W-1:0] trial;
        logic [RES_W-1:0] res_next;
        logic [SUM_W-1:0] n_next;

        always_comb
        begin
            trial = rt_res_reg[t] + BIT;
            if ({1'b0, rt_n_reg[t]} >= trial)
            begin
                n_next   = rt_n_reg[t] - trial[SUM_W-1:0];
                res_next = (rt_res_reg[t] >> 1) + BIT;
            end
            else
            begin
                n_next   = rt_n_reg[t];
                res_next = rt_res_reg[t] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rt_valid_reg[t+1] <= 1'b0;
            end
            else if (ctl.en)
            begin
                rt_valid_reg[t+1] <= rt_valid_reg[t];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                rt_car_reg[t+1] <= rt_car_reg[t];
                rt_n_reg[t+1]   <= n_next;
                rt_res_reg[t+1] <= res_next;
            end
        end
    end

    // Division of each aligned magnitude by the length, one quotient bit per
    // stage. Entry 0 holds the rounded numerator split into a partial
    // remainder and the bits still to be brought down.
    logic [LEN_W-1:0]   len;
    logic               dv_valid_reg [DIV_STEPS+1];
    carry_t             dv_car_reg   [DIV_STEPS+1];
    logic [LEN_W-1:0]   dv_len_reg   [DIV_STEPS+1];
    logic [LEN_W-1:0]   dv_r_reg     [DIV_STEPS+1][3];
    logic [Q_W-1:0]     dv_lo_reg    [DIV_STEPS+1][3];
    logic [Q_W-1:0]     dv_q_reg     [DIV_STEPS+1][3];
    logic [NUM_W-1:0]   num_next     [3];

    assign len = rt_res_reg[ROOT_STEPS][LEN_W-1:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_next[i] = {1'b0, rt_car_reg[ROOT_STEPS].nm[i], {NRM_W{1'b0}}}
                          + NUM_W'(len >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (ctl.en)
        begin
            dv_valid_reg[0] <= rt_valid_reg[ROOT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            dv_car_reg[0] <= rt_car_reg[ROOT_STEPS];
            dv_len_reg[0] <= len;
            for (int i = 0; i < 3; i++)
            begin
                dv_r_reg[0][i]  <= LEN_W'(num_next[i][NUM_W-1:Q_W]);
                dv_lo_reg[0][i] <= num_next[i][Q_W-1:0];
                dv_q_reg[0][i]  <= '0;
            end
        end
    end

    for (genvar t = 0; t < DIV_STEPS; t++)
    begin : g_div
        logic [LEN_W:0]   r2   [3];
        logic [LEN_W-1:0] r_next [3];
        logic [2:0]       qbit;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                r2[i] = {dv_r_reg[t][i], dv_lo_reg[t][i][Q_W-1-t]};
                if (r2[i] >= {1'b0, dv_len_reg[t]})
                begin
                    r_next[i] = LEN_W'(r2[i] - {1'b0, dv_len_reg[t]});
                    qbit[i]   = 1'b1;
                end
                else
                begin
                    r_next[i] = r2[i][LEN_W-1:0];
                    qbit[i]   = 1'b0;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[t+1] <= 1'b0;
            end
            else if (ctl.en)
            begin
                dv_valid_reg[t+1] <= dv_valid_reg[t];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                dv_car_reg[t+1] <= dv_car_reg[t];
                dv_len_reg[t+1] <= dv_len_reg[t];
                for (int i = 0; i < 3; i++)
                begin
                    dv_r_reg[t+1][i]  <= r_next[i];
                    dv_lo_reg[t+1][i] <= dv_lo_reg[t][i];
                    dv_q_reg[t+1][i]  <= {dv_q_reg[t][i][Q_W-2:0], qbit[i]};
                end
            end
        end
    end

    // Final stage: restore signs; a zero vector stays zero.
    logic                               fin_valid_reg;
    logic signed [rbv_pkg::UNIT_W-1:0]  fin_u_reg [3];
    logic [SIDE_W-1:0]                  fin_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            fin_valid_reg <= dv_valid_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            fin_side_reg <= dv_car_reg[DIV_STEPS].side;
            for (int i = 0; i < 3; i++)
            begin
                if (dv_car_reg[DIV_STEPS].zero)
                begin
                    fin_u_reg[i] <= '0;
                end
                else if (dv_car_reg[DIV_STEPS].neg[i])
                begin
                    fin_u_reg[i] <= -rbv_pkg::UNIT_W'(dv_q_reg[DIV_STEPS][i]);
                end
                else
                begin
                    fin_u_reg[i] <= rbv_pkg::UNIT_W'(dv_q_reg[DIV_STEPS][i]);
                end
            end
        end
    end

    assign valid    = fin_valid_reg;
    assign u        = fin_u_reg;
    assign side_out = fin_side_reg;

endmodule

[tb/rotation_between_vectors_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotation_between_vectors_core_test
// Self-checking bench for the vector-to-vector rotation core. Vector pair
// requests go in through a table of directed cases and then a random
// stream. Known directed rows carry their own matrix, all else goes to a
// fixed-point Rodrigues predictor written here. Each result is compared
// field by field with the oldest expectation. Both sides stall at random,
// and once the output holds off long enough to back up the whole pipeline.
// ----------------------------------------------------------------------------
module rotation_between_vectors_core_test;

    localparam int CW       = rbv_pkg::DEF_COMPONENT_WIDTH;
    localparam int OFB      = rbv_pkg::DEF_OUT_FRAC_BITS;
    localparam int OW       = OFB + 2;
    localparam int QF       = 30;
    localparam int LATENCY  = 153;
    localparam int N_RANDOM = 1730;
    localparam logic signed [OW-1:0] ONE = OW'(1 <<< OFB);

    typedef struct {
        logic signed [CW-1:0] src[3];
        logic signed [CW-1:0] dst[3];
    } vec_pair_t;

    typedef struct {
        logic signed [OW-1:0] m[9];
        logic                 degenerate;
    } matrix_t;

    // Directed row: when known is set, the matrix is diag * identity.
    typedef struct {
        vec_pair_t            pair;
        bit                   known;
        logic signed [OW-1:0] diag;
        logic                 degenerate;
    } case_row_t;

    logic clk;
    logic rst_n;
    int   errors;
    bit   sending_done;
    bit   calm;
    bit   hold_output;
    matrix_t pending_matrices[$];

    rbv_vec_if vec_ch();
    rbv_mat_if mat_ch();

    rotation_between_vectors_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .vec   (vec_ch),
        .mat   (mat_ch)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------
    function automatic longint round_shift(longint x, int n);
        longint half;
        if (n == 0)
        begin
            return x;
        end
        half = 64'sd1 <<< (n - 1);
        if (x >= 0)
        begin
            return (x + half) >>> n;
        end
        return -((-x + half) >>> n);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Unit vector in Q1.30; the zero vector stays zero.
    task automatic normalize(input longint a[3], output longint u[3]);
        longint unsigned mag[3];
        longint unsigned top;
        longint unsigned sumsq;
        longint unsigned len;
        longint          q;
        top   = 0;
        sumsq = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (a[i] < 0) ? longint'(-a[i]) : longint'(a[i]);
            if (mag[i] > top)
            begin
                top = mag[i];
            end
        end
        if (top == 0)
        begin
            u = '{0, 0, 0};
            return;
        end
        while (top >= (64'd1 << 30))
        begin
            top = top >> 1;
            for (int i = 0; i < 3; i++)
            begin
                mag[i] = mag[i] >> 1;
            end
        end
        while (top < (64'd1 << 29))
        begin
            top = top << 1;
            for (int i = 0; i < 3; i++)
            begin
                mag[i] = mag[i] << 1;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            sumsq += mag[i] * mag[i];
        end
        len = int_sqrt(sumsq);
        for (int i = 0; i < 3; i++)
        begin
            q    = longint'(((mag[i] << QF) + len / 2) / len);
            u[i] = (a[i] < 0) ? -q : q;
        end
    endtask

    function automatic logic signed [OW-1:0] to_q2(longint x);
        longint q;
        q = round_shift(x, QF - OFB);
        if (q > (64'sd1 <<< OFB))
        begin
            q = 64'sd1 <<< OFB;
        end
        if (q < -(64'sd1 <<< OFB))
        begin
            q = -(64'sd1 <<< OFB);
        end
        return q[OW-1:0];
    endfunction

    task automatic predict_rotation(input vec_pair_t p, output matrix_t r);
        longint a[3], b[3], u[3], w[3], s[3], v[3], vt[3];
        longint c, omc, d0, d1, d2, p01, p02, p12;
        bit     degen;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = p.src[i];
            b[i] = p.dst[i];
        end
        degen = (a[1] * b[2] == a[2] * b[1]) && (a[2] * b[0] == a[0] * b[2]) &&
                (a[0] * b[1] == a[1] * b[0]);
        normalize(a, u);
        normalize(b, w);
        s[0] = round_shift(u[1] * w[2] - u[2] * w[1], QF);
        s[1] = round_shift(u[2] * w[0] - u[0] * w[2], QF);
        s[2] = round_shift(u[0] * w[1] - u[1] * w[0], QF);
        c    = round_shift(u[0] * w[0] + u[1] * w[1] + u[2] * w[2], QF);
        if (degen)
        begin
            s = '{0, 0, 0};
            v = '{0, 0, 0};
        end
        else
        begin
            normalize(s, v);
        end
        omc = (64'sd1 <<< QF) - c;
        for (int i = 0; i < 3; i++)
        begin
            vt[i] = round_shift(omc * v[i], QF);
        end
        d0  = round_shift(vt[0] * v[0], QF) + c;
        d1  = round_shift(vt[1] * v[1], QF) + c;
        d2  = round_shift(vt[2] * v[2], QF) + c;
        p01 = round_shift(vt[0] * v[1], QF);
        p02 = round_shift(vt[2] * v[0], QF);
        p12 = round_shift(vt[1] * v[2], QF);
        r.m[0] = to_q2(d0);
        r.m[1] = to_q2(p01 - s[2]);
        r.m[2] = to_q2(p02 + s[1]);
        r.m[3] = to_q2(p01 + s[2]);
        r.m[4] = to_q2(d1);
        r.m[5] = to_q2(p12 - s[0]);
        r.m[6] = to_q2(p02 - s[1]);
        r.m[7] = to_q2(p12 + s[0]);
        r.m[8] = to_q2(d2);
        r.degenerate = degen;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        if (calm)
        begin
            return 0;
        end
        if ($urandom_range(0, 11) == 0)
        begin
            return $urandom_range(12, 45);
        end
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    function automatic vec_pair_t mk(int fx, int fy, int fz, int tx, int ty, int tz);
        vec_pair_t p;
        p.src = '{fx[CW-1:0], fy[CW-1:0], fz[CW-1:0]};
        p.dst = '{tx[CW-1:0], ty[CW-1:0], tz[CW-1:0]};
        return p;
    endfunction

    function automatic vec_pair_t random_pair();
        vec_pair_t p;
        int        k;
        int        pick;
        pick = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++)
        begin
            p.src[i] = CW'($urandom);
            p.dst[i] = CW'($urandom);
        end
        case (pick)
            // Parallel or antiparallel: target is a scaled copy of the source.
            0, 1:
            begin
                k = $urandom_range(1, 300) * (($urandom_range(0, 1) == 0) ? 1 : -1);
                for (int i = 0; i < 3; i++)
                begin
                    p.src[i] = CW'($urandom_range(0, 200) - 100);
                    p.dst[i] = CW'(p.src[i] * k);
                end
            end
            // Nearly parallel: one small nudge on a large vector.
            2:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    p.dst[i] = p.src[i];
                end
                p.dst[$urandom_range(0, 2)] ^= CW'($urandom_range(1, 3));
            end
            // A zero vector on one side.
            3:
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    p.src = '{0, 0, 0};
                end
                else
                begin
                    p.dst = '{0, 0, 0};
                end
            end
            // Short vectors, where normalization shifts the most.
            4, 5:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    p.src[i] = CW'($urandom_range(0, 6) - 3);
                    p.dst[i] = CW'($urandom_range(0, 6) - 3);
                end
            end
            // Components at the ends of the range.
            6:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        p.src[i] = CW'(($urandom_range(0, 1) == 0) ? -32768 : 32767);
                    end
                end
            end
            default:
            begin
            end
        endcase
        return p;
    endfunction

    task automatic send_pair(input vec_pair_t p, input bit known, input matrix_t typed);
        matrix_t r;
        int      gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            vec_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vec_ch.valid  <= 1'b1;
        vec_ch.from_x <= p.src[0];
        vec_ch.from_y <= p.src[1];
        vec_ch.from_z <= p.src[2];
        vec_ch.to_x   <= p.dst[0];
        vec_ch.to_y   <= p.dst[1];
        vec_ch.to_z   <= p.dst[2];
        do
        begin
            @(posedge clk);
        end
        while (!vec_ch.ready);
        if (known)
        begin
            r = typed;
        end
        else
        begin
            predict_rotation(p, r);
        end
        pending_matrices.push_back(r);
    endtask

    initial
    begin
        case_row_t rows[$];
        matrix_t   typed;
        vec_ch.valid  <= 1'b0;
        vec_ch.from_x <= '0;
        vec_ch.from_y <= '0;
        vec_ch.from_z <= '0;
        vec_ch.to_x   <= '0;
        vec_ch.to_y   <= '0;
        vec_ch.to_z   <= '0;
        rst_n         <= 1'b0;
        errors        = 0;
        sending_done  = 0;
        calm          = 0;
        hold_output   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = '{
            '{mk(0, 0, 0, 0, 0, 0),                       1, 0,     1},
            '{mk(0, 0, 0, 5, 6, 7),                       1, 0,     1},
            '{mk(-3, 9, 1, 0, 0, 0),                      1, 0,     1},
            '{mk(1, 0, 0, 1, 0, 0),                       1, ONE,   1},
            '{mk(0, -32768, 0, 0, -5, 0),                 1, ONE,   1},
            '{mk(32767, 0, 0, -32768, 0, 0),              1, -ONE,  1},
            '{mk(0, 0, 7, 0, 0, -7),                      1, -ONE,  1},
            '{mk(1, 0, 0, 0, 1, 0),                       0, 0,     0},
            '{mk(0, 1, 0, 0, 0, 1),                       0, 0,     0},
            '{mk(0, 0, 1, 1, 0, 0),                       0, 0,     0},
            '{mk(-32768, -32768, -32768, 32767, 32767, 32767), 0, 0, 0},
            '{mk(-32768, -32768, -32768, -32768, 32767, -32768), 0, 0, 0},
            '{mk(32767, 32767, 32767, 32767, 32767, 32766), 0, 0,   0},
            '{mk(32767, -32768, 1, -1, 32767, -32768),    0, 0,     0},
            '{mk(3, 4, 0, 4, -3, 0),                      0, 0,     0},
            '{mk(1, 1, 1, -1, -1, 1),                     0, 0,     0},
            '{mk(2, 4, 6, 1, 2, 3),                       0, 0,     0},
            '{mk(-1, 2, -3, 3, -2, 1),                    0, 0,     0},
            '{mk(1, 0, 0, 32767, 1, 0),                   0, 0,     0},
            '{mk(21845, -10922, 5461, -5461, 10922, 21845), 0, 0,   0}
        };
        foreach (rows[i])
        begin
            for (int j = 0; j < 9; j++)
            begin
                typed.m[j] = (j % 4 == 0) ? rows[i].diag : '0;
            end
            typed.degenerate = rows[i].degenerate;
            send_pair(rows[i].pair, rows[i].known, typed);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            calm = (n >= 600 && n < 900);
            // Back up the whole pipeline once.
            if (n == 300)
            begin
                hold_output = 1;
            end
            send_pair(random_pair(), 0, typed);
        end
        vec_ch.valid <= 1'b0;
        sending_done = 1;
    end

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------
    initial
    begin
        int gap;
        mat_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_output)
            begin
                hold_output = 0;
                mat_ch.ready <= 1'b0;
                repeat (399) @(posedge clk);
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    mat_ch.ready <= 1'b0;
                    repeat (gap - 1) @(posedge clk);
                end
                else
                begin
                    mat_ch.ready <= 1'b1;
                end
            end
        end
    end

    task automatic check_field(string name, logic signed [OW-1:0] want,
                               logic signed [OW-1:0] got);
        if (got !== want)
        begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $realtime, name,
                     want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        matrix_t want;
        logic signed [OW-1:0] got[9];
        if (rst_n && mat_ch.valid && mat_ch.ready)
        begin
            if (pending_matrices.size() == 0)
            begin
                $display("%0t: matrix request with nothing expected", $realtime);
                errors++;
            end
            else
            begin
                want = pending_matrices.pop_front();
                got  = '{mat_ch.m00, mat_ch.m01, mat_ch.m02, mat_ch.m10, mat_ch.m11,
                         mat_ch.m12, mat_ch.m20, mat_ch.m21, mat_ch.m22};
                for (int j = 0; j < 9; j++)
                begin
                    check_field($sformatf("m%0d%0d", j / 3, j % 3), want.m[j], got[j]);
                end
                if (mat_ch.degenerate !== want.degenerate)
                begin
                    $display("%0t: mismatch on degenerate: expected %0b, actual %0b",
                             $realtime, want.degenerate, mat_ch.degenerate);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        wait (sending_done);
        wait (pending_matrices.size() == 0);
        repeat (LATENCY + 50) @(posedge clk);
        if (errors == 0 && pending_matrices.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("timeout with %0d matrices outstanding", pending_matrices.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
